/* design/cdpc_pkg.sv */
// Package for the crash detector with peak capture.
// Holds the sample and result types, configuration codes and the saturating
// absolute value helper. No dependencies.
`default_nettype none

package cdpc_pkg;

    // Fixed field widths.
    localparam int AXIS_W = 16;
    localparam int MAG_W  = 15;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CRASH_THRESHOLD = 2'd0,
        CFG_USE_Z_AXIS      = 2'd1
    } t_cfg_index;

    localparam logic [MAG_W-1:0] THRESHOLD_RESET = 15'd30000;
    localparam logic [MAG_W-1:0] MAG_MAX         = 15'h7FFF;
    localparam logic [AXIS_W-1:0] AXIS_MOST_NEG  = 16'h8000;

    // Default depth of both queues.
    localparam int CDPC_QUEUE_DEPTH = 2;

    // A classified sample, as it travels from the front end to the back end.
    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
        logic        [MAG_W-1:0]  mag;
    } t_sample;

    // One result item.
    typedef struct packed {
        logic        [MAG_W-1:0]  magnitude;
        logic                     in_crash;
        logic                     crash_over;
        logic signed [AXIS_W-1:0] peak_x;
        logic signed [AXIS_W-1:0] peak_y;
        logic signed [AXIS_W-1:0] peak_z;
        logic        [MAG_W-1:0]  peak_mag;
    } t_result;

    // Absolute value of a two's complement sample, with the most negative
    // value clamped to the largest positive one.
    function automatic logic [MAG_W-1:0] sat_abs(input logic [AXIS_W-1:0] a);
        logic [AXIS_W-1:0] neg;
        neg = AXIS_W'(~a + 1'b1);
        if (!a[AXIS_W-1]) begin
            return a[MAG_W-1:0];
        end else if (a == AXIS_MOST_NEG) begin
            return MAG_MAX;
        end else begin
            return neg[MAG_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* design/cdpc_queue.sv */
// Small synchronous queue used between the front and back ends and to hold
// finished results. Depends on nothing but its parameters.
`default_nettype none

module cdpc_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr_ptr + 1'b1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(r_rd_ptr + 1'b1);
        end
        if (w_push && !w_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (w_pop && !w_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/cdpc_front.sv */
// Front end: forms the sample magnitude from the saturated axis values.
// Depends on cdpc_pkg.
`default_nettype none

module cdpc_front
    import cdpc_pkg::*;
(
    input  wire logic signed [AXIS_W-1:0] i_accel_x,
    input  wire logic signed [AXIS_W-1:0] i_accel_y,
    input  wire logic signed [AXIS_W-1:0] i_accel_z,
    input  wire logic                     i_use_z_axis,
    output t_sample                       o_sample
);

    logic [MAG_W-1:0] w_abs_x, w_abs_y, w_abs_z, w_max_xy;

    always_comb begin
        w_abs_x  = sat_abs(i_accel_x);
        w_abs_y  = sat_abs(i_accel_y);
        w_abs_z  = sat_abs(i_accel_z);
        w_max_xy = (w_abs_y > w_abs_x) ? w_abs_y : w_abs_x;

        o_sample.x   = i_accel_x;
        o_sample.y   = i_accel_y;
        o_sample.z   = i_accel_z;
        o_sample.mag = (i_use_z_axis && (w_abs_z > w_max_xy)) ? w_abs_z : w_max_xy;
    end

endmodule

`default_nettype wire

/* design/cdpc_back.sv */
// Back end: crash state and held peak, updated once per classified sample.
// Depends on cdpc_pkg.
`default_nettype none

module cdpc_back
    import cdpc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_sample          i_sample,
    input  wire logic             i_space,
    input  wire logic [MAG_W-1:0] i_threshold,
    output logic                  o_take,
    output t_result               o_result
);

    logic                     r_active, n_active;
    logic signed [AXIS_W-1:0] r_held_x, r_held_y, r_held_z;
    logic        [MAG_W-1:0]  r_held_mag;
    logic                     w_capture, w_over;

    assign o_take = i_valid && i_space;

    always_comb begin
        n_active  = r_active;
        w_capture = 1'b0;
        w_over    = 1'b0;
        if (!r_active) begin
            if (i_sample.mag > i_threshold) begin
                n_active  = 1'b1;
                w_capture = 1'b1;
            end
        end else if (i_sample.mag < i_threshold) begin
            n_active = 1'b0;
            w_over   = 1'b1;
        end else if (i_sample.mag > r_held_mag) begin
            w_capture = 1'b1;
        end

        o_result.magnitude  = i_sample.mag;
        o_result.in_crash   = n_active;
        o_result.crash_over = w_over;
        o_result.peak_x     = w_capture ? i_sample.x   : r_held_x;
        o_result.peak_y     = w_capture ? i_sample.y   : r_held_y;
        o_result.peak_z     = w_capture ? i_sample.z   : r_held_z;
        o_result.peak_mag   = w_capture ? i_sample.mag : r_held_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_held_x   <= '0;
            r_held_y   <= '0;
            r_held_z   <= '0;
            r_held_mag <= '0;
        end else if (o_take) begin
            r_active <= n_active;
            if (w_capture) begin
                r_held_x   <= i_sample.x;
                r_held_y   <= i_sample.y;
                r_held_z   <= i_sample.z;
                r_held_mag <= i_sample.mag;
            end
        end
    end

endmodule

`default_nettype wire

/* design/crash_detect_peak_capture.sv */
// Top level of the crash detector with peak capture.
// Depends on cdpc_pkg, cdpc_front, cdpc_queue and cdpc_back.
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ------------------------------
//  sample    in         i_push / o_full           i_accel_x, i_accel_y, i_accel_z
//  result    out        o_empty / i_pop           o_magnitude .. o_peak_mag
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A sample is classified in the cycle of its transfer and lands in a short
// queue; the back end takes one sample per cycle from it while the result queue
// has room, updates the crash state and pushes the result into the result
// queue. A result passes both queues before it can be popped, and one sample
// per cycle is sustained while results are popped as fast. Stalls on the result
// side fill the result queue first, then the sample queue, and only then raise
// o_full. Reset is synchronous and active low; it empties both queues, clears
// the crash state and the held peak and loads the configuration defaults.
`default_nettype none

module crash_detect_peak_capture
    import cdpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = CDPC_QUEUE_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Sample channel.
    input  wire logic                     i_push,
    output logic                          o_full,
    input  wire logic signed [AXIS_W-1:0] i_accel_x,
    input  wire logic signed [AXIS_W-1:0] i_accel_y,
    input  wire logic signed [AXIS_W-1:0] i_accel_z,
    // Result channel.
    output logic                          o_empty,
    input  wire logic                     i_pop,
    output logic        [MAG_W-1:0]       o_magnitude,
    output logic                          o_in_crash,
    output logic                          o_crash_over,
    output logic signed [AXIS_W-1:0]      o_peak_x,
    output logic signed [AXIS_W-1:0]      o_peak_y,
    output logic signed [AXIS_W-1:0]      o_peak_z,
    output logic        [MAG_W-1:0]       o_peak_mag,
    // Configuration channel.
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data
);

    // Configuration registers. Writes always complete; an index past the
    // register list is accepted and ignored.
    logic [MAG_W-1:0] r_threshold;
    logic             r_use_z_axis;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RESET;
            r_use_z_axis <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CRASH_THRESHOLD: r_threshold  <= i_cfg_data[MAG_W-1:0];
                CFG_USE_Z_AXIS:      r_use_z_axis <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front end: magnitude of the incoming sample.
    t_sample w_front_sample;

    cdpc_front u_front (
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_use_z_axis (r_use_z_axis),
        .o_sample     (w_front_sample)
    );

    // Queue of classified samples between the two ends.
    t_sample w_mid_sample;
    logic    w_mid_empty;
    logic    w_take;

    cdpc_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_sample))
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_front_sample),
        .o_full  (o_full),
        .i_pop   (w_take),
        .o_data  (w_mid_sample),
        .o_empty (w_mid_empty)
    );

    // Back end: crash state machine and peak hold.
    t_result w_back_result;
    logic    w_out_full;

    cdpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!w_mid_empty),
        .i_sample    (w_mid_sample),
        .i_space     (!w_out_full),
        .i_threshold (r_threshold),
        .o_take      (w_take),
        .o_result    (w_back_result)
    );

    // Finished results wait here until popped.
    t_result w_out_result;

    cdpc_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_result))
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_data  (w_back_result),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (w_out_result),
        .o_empty (o_empty)
    );

    assign o_magnitude  = w_out_result.magnitude;
    assign o_in_crash   = w_out_result.in_crash;
    assign o_crash_over = w_out_result.crash_over;
    assign o_peak_x     = w_out_result.peak_x;
    assign o_peak_y     = w_out_result.peak_y;
    assign o_peak_z     = w_out_result.peak_z;
    assign o_peak_mag   = w_out_result.peak_mag;

    // A result that ends a crash never claims the crash is still running.
    a_over_not_in_crash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_crash_over) |-> !o_in_crash)
        else $error("crash end flagged while still in crash");

    // The back end moves a sample only when one waits and there is room.
    a_take_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (!w_mid_empty && !w_out_full))
        else $error("back end took a sample without data or room");

    // A transferred sample is held in the sample queue on the next cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> !w_mid_empty)
        else $error("accepted sample lost");

    // Reset leaves no result behind.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

endmodule

`default_nettype wire

/* verif/cdpc_result_check.sv */
// Result checker for crash_detect_peak_capture: follows the sample, result and
// configuration transfers, predicts every result and compares it field by field.
// Depends on cdpc_pkg for the field widths, the result type and the register codes.
module cdpc_result_check
    import cdpc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire logic                     i_full,
    input  wire logic signed [AXIS_W-1:0] i_accel_x,
    input  wire logic signed [AXIS_W-1:0] i_accel_y,
    input  wire logic signed [AXIS_W-1:0] i_accel_z,
    input  wire logic                     i_empty,
    input  wire logic                     i_pop,
    input  wire logic        [MAG_W-1:0]  i_magnitude,
    input  wire logic                     i_in_crash,
    input  wire logic                     i_crash_over,
    input  wire logic signed [AXIS_W-1:0] i_peak_x,
    input  wire logic signed [AXIS_W-1:0] i_peak_y,
    input  wire logic signed [AXIS_W-1:0] i_peak_z,
    input  wire logic        [MAG_W-1:0]  i_peak_mag,
    input  wire logic                     i_cfg_valid,
    input  wire logic                     i_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data,
    output int                            o_mismatches,
    output int                            o_pending
);

    localparam int PRINT_LIMIT = 100;

    // Local copy of the configuration and of the detector state.
    logic        [MAG_W-1:0]  threshold;
    logic                     use_z;
    logic                     crash_active;
    logic signed [AXIS_W-1:0] held_x;
    logic signed [AXIS_W-1:0] held_y;
    logic signed [AXIS_W-1:0] held_z;
    logic        [MAG_W-1:0]  held_mag;

    t_result expected_reports[$];
    int      mismatches = 0;
    int      waiting = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = waiting;

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT) begin
            $display("%0t mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    // Absolute value of one axis, clamped so that the most negative code
    // reads as full scale.
    function automatic logic [MAG_W-1:0] axis_strength(input logic [AXIS_W-1:0] a);
        logic [AXIS_W-1:0] flipped;
        flipped = -a;
        if (!a[AXIS_W-1]) begin
            return a[MAG_W-1:0];
        end
        if (flipped[AXIS_W-1]) begin
            return MAG_MAX;
        end
        return flipped[MAG_W-1:0];
    endfunction

    // Advances the detector by one sample and returns the result it reports.
    function automatic t_result step_detector(input logic [AXIS_W-1:0] x, y, z);
        t_result          r;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] part;
        logic             over;
        logic             capture;
        mag  = axis_strength(x);
        part = axis_strength(y);
        if (part > mag) begin
            mag = part;
        end
        part = axis_strength(z);
        if (use_z && part > mag) begin
            mag = part;
        end
        over    = 1'b0;
        capture = 1'b0;
        if (!crash_active) begin
            if (mag > threshold) begin
                crash_active = 1'b1;
                capture      = 1'b1;
            end
        end else if (mag < threshold) begin
            crash_active = 1'b0;
            over         = 1'b1;
        end else if (mag > held_mag) begin
            capture = 1'b1;
        end
        if (capture) begin
            held_x   = x;
            held_y   = y;
            held_z   = z;
            held_mag = mag;
        end
        r.magnitude  = mag;
        r.in_crash   = crash_active;
        r.crash_over = over;
        r.peak_x     = held_x;
        r.peak_y     = held_y;
        r.peak_z     = held_z;
        r.peak_mag   = held_mag;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            threshold    = THRESHOLD_RESET;
            use_z        = 1'b0;
            crash_active = 1'b0;
            held_x       = '0;
            held_y       = '0;
            held_z       = '0;
            held_mag     = '0;
            expected_reports.delete();
        end else begin
            // Results are taken first: a sample taken at this same edge cannot
            // have its result out yet.
            if (i_pop && !i_empty) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch($sformatf("result with magnitude %0d but none expected",
                                              i_magnitude));
                end else begin
                    want = expected_reports.pop_front();
                    if (i_magnitude !== want.magnitude)
                        report_mismatch($sformatf("magnitude %0d, expected %0d",
                                                  i_magnitude, want.magnitude));
                    if (i_in_crash !== want.in_crash)
                        report_mismatch($sformatf("in_crash %0b, expected %0b",
                                                  i_in_crash, want.in_crash));
                    if (i_crash_over !== want.crash_over)
                        report_mismatch($sformatf("crash_over %0b, expected %0b",
                                                  i_crash_over, want.crash_over));
                    if (i_peak_x !== want.peak_x)
                        report_mismatch($sformatf("peak_x %0d, expected %0d",
                                                  i_peak_x, want.peak_x));
                    if (i_peak_y !== want.peak_y)
                        report_mismatch($sformatf("peak_y %0d, expected %0d",
                                                  i_peak_y, want.peak_y));
                    if (i_peak_z !== want.peak_z)
                        report_mismatch($sformatf("peak_z %0d, expected %0d",
                                                  i_peak_z, want.peak_z));
                    if (i_peak_mag !== want.peak_mag)
                        report_mismatch($sformatf("peak_mag %0d, expected %0d",
                                                  i_peak_mag, want.peak_mag));
                end
            end
            if (i_push && !i_full) begin
                expected_reports.push_back(step_detector(i_accel_x, i_accel_y, i_accel_z));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CRASH_THRESHOLD: threshold = i_cfg_data;
                    CFG_USE_Z_AXIS:      use_z = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        waiting <= expected_reports.size();
    end

endmodule

/* verif/crash_detect_peak_capture_test.sv */
// Testbench top for crash_detect_peak_capture: drives samples, pops results and
// writes the threshold and axis registers; cdpc_result_check does the checking.
// Depends on cdpc_pkg, cdpc_result_check and the block itself.
module crash_detect_peak_capture_test;
    import cdpc_pkg::*;

    // Random samples per configuration phase, and the number of phases.
    localparam int RANDOM_PER_PHASE = 85;
    localparam int PHASES           = 8;
    // A result passes through the sample queue and the result queue, so a
    // handful of quiet cycles after the last result is plenty.
    localparam int SETTLE_CYCLES = 8;
    // Longest correct stretch without any transfer is a sender gap plus a
    // receiver stall plus the latency.
    localparam int STALL_LIMIT = 1000;
    localparam int FULL_SCALE  = int'(MAG_MAX);

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic signed [AXIS_W-1:0] accel_x = '0;
    logic signed [AXIS_W-1:0] accel_y = '0;
    logic signed [AXIS_W-1:0] accel_z = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic        [MAG_W-1:0]  magnitude;
    logic                     in_crash;
    logic                     crash_over;
    logic signed [AXIS_W-1:0] peak_x;
    logic signed [AXIS_W-1:0] peak_y;
    logic signed [AXIS_W-1:0] peak_z;
    logic        [MAG_W-1:0]  peak_mag;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    t_cfg_index               cfg_index = CFG_CRASH_THRESHOLD;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    int mismatch_total;
    int pending_results;

    // The setting currently loaded, used to shape the random samples.
    logic [MAG_W-1:0] cur_threshold = THRESHOLD_RESET;
    logic             cur_zaxis = 1'b0;
    // When set, neither side inserts any idle cycles.
    bit               calm = 1'b0;

    int samples_sent   = 0;
    int crash_ends     = 0;
    int settings_used  = 1;

    crash_detect_peak_capture uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_accel_x   (accel_x),
        .i_accel_y   (accel_y),
        .i_accel_z   (accel_z),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_magnitude (magnitude),
        .o_in_crash  (in_crash),
        .o_crash_over(crash_over),
        .o_peak_x    (peak_x),
        .o_peak_y    (peak_y),
        .o_peak_z    (peak_z),
        .o_peak_mag  (peak_mag),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cdpc_result_check result_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_accel_x   (accel_x),
        .i_accel_y   (accel_y),
        .i_accel_z   (accel_z),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_magnitude (magnitude),
        .i_in_crash  (in_crash),
        .i_crash_over(crash_over),
        .i_peak_x    (peak_x),
        .i_peak_y    (peak_y),
        .i_peak_z    (peak_z),
        .i_peak_mag  (peak_mag),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_mismatches(mismatch_total),
        .o_pending   (pending_results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle cycles before the next transfer on either side.
    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // An axis value whose clamped absolute value is m, with a random sign.
    // Full scale on the negative side is sometimes the most negative code,
    // which must read as full scale too.
    function automatic logic signed [AXIS_W-1:0] axis_of_strength(input int m);
        if ($urandom_range(0, 1) == 0) begin
            return AXIS_W'(m);
        end
        if (m == FULL_SCALE && $urandom_range(0, 1) == 1) begin
            return AXIS_MOST_NEG;
        end
        return AXIS_W'(-m);
    endfunction

    // Offers one sample after a random gap and returns at the edge of its
    // transfer. Push stays high so that the next sample can follow at once.
    task automatic send_sample(input logic signed [AXIS_W-1:0] x, y, z);
        int gap;
        gap = draw_wait();
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        accel_x <= x;
        accel_y <= y;
        accel_z <= z;
        @(posedge clk);
        while (full) @(posedge clk);
        samples_sent++;
    endtask

    // Sends a sample whose magnitude under the current setting is m. One axis
    // carries the magnitude and the others stay at or below it; with the Z axis
    // switched off, Z is left fully random since it must not matter.
    task automatic send_with_strength(input int m);
        int                       carrier;
        logic signed [AXIS_W-1:0] v[3];
        carrier = cur_zaxis ? $urandom_range(0, 2) : $urandom_range(0, 1);
        for (int k = 0; k < 3; k++) begin
            v[k] = axis_of_strength($urandom_range(0, m));
        end
        v[carrier] = axis_of_strength(m);
        if (!cur_zaxis) begin
            v[2] = AXIS_W'($urandom());
        end
        send_sample(v[0], v[1], v[2]);
    endtask

    // Stops offering samples and waits until every result has been popped,
    // then lets a few more cycles pass so the block is fully idle.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: pops with a random stall before each transfer, or back to
    // back while the bench is calm.
    initial begin
        int gap;
        wait (rst_n === 1'b1);
        forever begin
            gap = draw_wait();
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n && pop && !empty && crash_over) begin
            crash_ends <= crash_ends + 1;
        end
    end

    // Watchdog: ends the run if no transfer of any kind happens for too long.
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Watchdog: no transfer for %0d cycles.", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int               phase;
        int               thr;
        int               m;
        int               peak_seen;
        int               phase_start;
        logic [MAG_W-1:0] next_thr;
        logic             next_z;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples under the reset setting: threshold 30000, Z ignored.
        send_sample(0, 0, 0);                  // quiet, peak reads zero after reset
        send_sample(32767, 0, 0);              // full scale starts a crash
        send_sample(-32768, 0, 0);             // clamps to full scale, ties the peak
        send_sample(0, 30000, -32768);         // equal to threshold: crash goes on
        send_sample(-29999, 1, 32767);         // just below threshold ends it
        send_sample(30000, 0, 0);              // equal to threshold starts nothing
        send_sample(0, 0, -32768);             // Z alone is ignored in this mode
        send_sample(30001, -30001, 0);         // one above threshold starts a crash
        send_sample(-1, -30500, 7);            // larger magnitude replaces the peak
        send_sample(0, -30002, 0);             // smaller one does not
        send_sample(0, 0, 0);                  // crash over
        send_sample(-1, 1, -1);
        send_sample(32767, -32768, 16'sh5555); // starts with X and Y both at full scale
        send_sample(-32767, 16'sh2AAA, -16'sh2AAB);
        send_sample(21845, -21846, 0);         // ends it
        settle();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    next_thr = THRESHOLD_RESET;
                    next_z   = 1'b1;
                end
                1: begin
                    next_thr = '0;
                    next_z   = 1'b1;
                end
                2: begin
                    next_thr = MAG_MAX;
                    next_z   = 1'b0;
                end
                3: begin
                    next_thr = 15'd1;
                    next_z   = 1'b1;
                end
                4: begin
                    next_thr = MAG_MAX - 1'b1;
                    next_z   = 1'b0;
                end
                6: begin
                    next_thr = MAG_W'($urandom_range(1, 200));
                    next_z   = 1'($urandom_range(0, 1));
                end
                default: begin
                    next_thr = MAG_W'($urandom_range(0, FULL_SCALE));
                    next_z   = 1'($urandom_range(0, 1));
                end
            endcase

            // Both registers are written back to back while the block is idle.
            // Only bit 0 of the axis register counts, so the upper data bits are
            // filled with noise.
            cfg_valid <= 1'b1;
            cfg_index <= CFG_CRASH_THRESHOLD;
            cfg_data  <= next_thr;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            cfg_index <= CFG_USE_Z_AXIS;
            cfg_data  <= {(CFG_DATA_W - 1)'($urandom()), next_z};
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            cfg_valid <= 1'b0;
            cur_threshold = next_thr;
            cur_zaxis     = next_z;
            settings_used++;
            calm = (phase % 3 == 2);

            if (phase == 0) begin
                // Directed samples with the Z axis included.
                send_sample(0, 0, -32768);     // Z alone starts a crash at full scale
                send_sample(0, 0, 32767);      // tie with the held peak
                send_sample(100, -100, -30000);// equal to threshold via Z
                send_sample(0, 0, 29999);      // ends it
                send_sample(0, 0, 30001);
                send_sample(0, 0, -100);
                send_sample(-30001, 0, 30002); // Z wins over a smaller X, starting a crash
                send_sample(0, 0, 0);
            end

            // Random part: mostly whole crash episodes with random content,
            // some fully random samples in between.
            thr         = int'(cur_threshold);
            phase_start = samples_sent;
            while (samples_sent - phase_start < RANDOM_PER_PHASE) begin
                if ($urandom_range(0, 9) < 2) begin
                    send_sample(AXIS_W'($urandom()), AXIS_W'($urandom()),
                                AXIS_W'($urandom()));
                end else begin
                    repeat ($urandom_range(0, 3)) begin
                        send_with_strength($urandom_range(0, thr));
                    end
                    // At full-scale threshold no crash can start.
                    if (thr < FULL_SCALE) begin
                        peak_seen = $urandom_range(thr + 1, FULL_SCALE);
                        send_with_strength(peak_seen);
                        repeat ($urandom_range(1, 6)) begin
                            case ($urandom_range(0, 4))
                                0: m = thr;
                                1: m = peak_seen;
                                2: m = (peak_seen < FULL_SCALE) ? peak_seen + 1 : peak_seen;
                                default: m = $urandom_range(thr, FULL_SCALE);
                            endcase
                            if (m > peak_seen) begin
                                peak_seen = m;
                            end
                            send_with_strength(m);
                        end
                        // At zero threshold a crash never ends.
                        if (thr > 0) begin
                            send_with_strength($urandom_range(0, thr - 1));
                        end
                    end
                end
            end
            settle();
        end

        $display("Sent %0d samples under %0d threshold and axis settings, idling at random",
                 samples_sent, settings_used);
        $display("and back to back; %0d crash endings seen, %0d mismatches.",
                 crash_ends, mismatch_total);
        if (mismatch_total == 0 && pending_results == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
